// ===== sv/lrp_pkg.sv =====
// Shared constants for the LRU page replacement block.
// No dependencies; compile first.
package lrp_pkg;

  // Build-time defaults for the top-level parameters
  localparam int unsigned FRAMES_DEF    = 8;
  localparam int unsigned PAGE_BITS_DEF = 16;

  // Counter and configuration widths
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned ACT_W  = 4;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  localparam logic [CNT_W-1:0] CNT_MAX    = '1;
  localparam logic [ACT_W-1:0] ACT_RESET  = 4'd8;

  // Register word index, taken from paddr[2]
  localparam logic REG_ACTIVE = 1'b0;

endpackage

// ===== sv/lrp_if.sv =====
// Handshake channels of the LRU page replacement block: page reference in,
// lookup result out. Depends on lrp_pkg for parameter defaults.
interface lrp_req_if #(
  parameter int unsigned PAGE_BITS = lrp_pkg::PAGE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lrp_res_if #(
  parameter int unsigned FRAMES    = lrp_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = lrp_pkg::PAGE_BITS_DEF
);
  localparam int unsigned IDX_W = $clog2(FRAMES);

  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [IDX_W-1:0]           frame_index;
  logic                       evicted_valid;
  logic [PAGE_BITS-1:0]       evicted_page;
  logic [lrp_pkg::CNT_W-1:0]  fault_total;
  logic [lrp_pkg::CNT_W-1:0]  hit_total;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_total, output hit_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_total, input hit_total, output ready);
endinterface

// ===== sv/lrp_cell.sv =====
// One frame cell of the LRU chain: holds page, valid bit and recency rank,
// folds its frame into the search token and passes it on. Types come from the top.
module lrp_cell #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned IDX_W     = 3,
  parameter int unsigned ACTC_W    = 4,
  parameter int unsigned PAGE_BITS = 16,
  parameter type         tok_t     = logic,
  parameter type         upd_t     = logic
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [PAGE_BITS-1:0] query_i,
  input  logic [ACTC_W-1:0]    act_i,
  input  tok_t                 tok_i,
  input  upd_t                 upd_i,
  output tok_t                 tok_o
);

  localparam logic [IDX_W-1:0]  MY_IDX = IDX_W'(INDEX);
  localparam logic [ACTC_W-1:0] MY_POS = ACTC_W'(INDEX);
  localparam bit                FIRST  = (INDEX == 0);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [IDX_W-1:0]     rank_q;
  tok_t                 tok_d, tok_q;
  logic                 active;

  assign active = MY_POS < act_i;

  always_comb begin
    tok_d = tok_i;
    if (active) begin
      // first matching frame wins
      if (valid_q && (page_q == query_i) && !tok_i.hit) begin
        tok_d.hit      = 1'b1;
        tok_d.hit_idx  = MY_IDX;
        tok_d.hit_rank = rank_q;
      end
      // first empty frame wins
      if (!valid_q && !tok_i.empty) begin
        tok_d.empty     = 1'b1;
        tok_d.empty_idx = MY_IDX;
      end
      // oldest frame: strictly larger rank replaces, so ties keep the lower frame
      if (FIRST || (rank_q > tok_i.best_rank)) begin
        tok_d.best_rank = rank_q;
        tok_d.best_idx  = MY_IDX;
        tok_d.best_page = page_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else if (upd_i.en) begin
      if (upd_i.idx == MY_IDX) begin
        valid_q <= 1'b1;
        rank_q  <= '0;
      end else if (valid_q && (!upd_i.was_valid || (rank_q < upd_i.rank))) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.wr_page && (upd_i.idx == MY_IDX)) begin
      page_q <= upd_i.page;
    end
  end

endmodule

// ===== sv/lru_page_replacement.sv =====
// LRU page replacement: top level with controller, counters and APB register.
// Depends on lrp_pkg, lrp_if (lrp_req_if, lrp_res_if) and lrp_cell.
//
//   channel  dir  handshake        beat contents
//   req_i    in   valid/ready      page_number
//   res_o    out  valid/ready      hit, frame_index, evicted_valid, evicted_page,
//                                  fault_total, hit_total
//   apb      in   psel/penable     active_frames at paddr 0 (pready tied high)
//
// One reference at a time: the search token walks the FRAMES cells one per cycle,
// is caught in the pending register, then decides; the result is offered once the
// decision is registered, and a new reference waits until then.
// Reset empties every frame, zeroes ranks and counts, active_frames = 8.
// A result that is not taken holds the finished decision; the next reference
// is accepted as soon as the decision has been written to the result register.
module lru_page_replacement #(
  parameter int unsigned FRAMES    = lrp_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = lrp_pkg::PAGE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lrp_req_if.sink                      req_i,
  lrp_res_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lrp_pkg::APB_AW-1:0]   paddr,
  input  logic [lrp_pkg::APB_DW-1:0]   pwdata,
  output logic [lrp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import lrp_pkg::*;

  localparam int unsigned IDX_W  = $clog2(FRAMES);
  localparam int unsigned ACTC_W = $clog2(FRAMES + 1);

  // Search token handed from cell to cell
  typedef struct packed {
    logic                 vld;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     hit_rank;
    logic                 empty;
    logic [IDX_W-1:0]     empty_idx;
    logic [IDX_W-1:0]     best_rank;
    logic [IDX_W-1:0]     best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } tok_t;

  // Update broadcast to every cell
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic                 was_valid;
    logic [IDX_W-1:0]     rank;
    logic                 wr_page;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [ACT_W-1:0]  act_raw_q;
  logic [ACTC_W-1:0] act;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_raw_q <= ACT_RESET;
    end else if (cfg_wr && (paddr[2] == REG_ACTIVE)) begin
      act_raw_q <= pwdata[ACT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACTIVE: prdata = APB_DW'(act_raw_q);
      default:    prdata = '0;
    endcase
  end

  // Clamp the count: zero acts as one, anything past the built frames as FRAMES
  always_comb begin
    if (act_raw_q == '0) begin
      act = ACTC_W'(1);
    end else if (32'(act_raw_q) > 32'(FRAMES)) begin
      act = ACTC_W'(FRAMES);
    end else begin
      act = ACTC_W'(act_raw_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Control: accept, launch the token, catch it at the end of the row
  // ---------------------------------------------------------------------------
  logic                 busy_q, start_q, pend_valid_q, res_valid_q;
  logic [PAGE_BITS-1:0] query_q;
  tok_t                 pend_q;
  tok_t                 tok_chain [FRAMES+1];
  upd_t                 upd;
  logic                 accept, fire;

  assign req_i.ready = !busy_q;
  assign accept      = req_i.valid && !busy_q;
  assign fire        = pend_valid_q && (!res_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      start_q      <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      start_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (fire) begin
        busy_q <= 1'b0;
      end
      if (tok_chain[FRAMES].vld) begin
        pend_valid_q <= 1'b1;
      end else if (fire) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q <= req_i.page_number;
    end
    if (tok_chain[FRAMES].vld) begin
      pend_q <= tok_chain[FRAMES];
    end
  end

  // Launch token: empty search state, marked valid in the cycle after accept
  always_comb begin
    tok_chain[0]     = '0;
    tok_chain[0].vld = start_q;
  end

  // ---------------------------------------------------------------------------
  // Row of frame cells
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < FRAMES; j++) begin : g_cell
    lrp_cell #(
      .INDEX     (j),
      .IDX_W     (IDX_W),
      .ACTC_W    (ACTC_W),
      .PAGE_BITS (PAGE_BITS),
      .tok_t     (tok_t),
      .upd_t     (upd_t)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .query_i (query_q),
      .act_i   (act),
      .tok_i   (tok_chain[j]),
      .upd_i   (upd),
      .tok_o   (tok_chain[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Decision: hit, else fill the first empty frame, else replace the oldest
  // ---------------------------------------------------------------------------
  logic                 evict;
  logic [PAGE_BITS-1:0] evicted_page;

  always_comb begin
    upd.en    = fire;
    upd.page  = query_q;
    evict        = 1'b0;
    evicted_page = '0;
    if (pend_q.hit) begin
      upd.idx       = pend_q.hit_idx;
      upd.rank      = pend_q.hit_rank;
      upd.was_valid = 1'b1;
      upd.wr_page   = 1'b0;
    end else if (pend_q.empty) begin
      upd.idx       = pend_q.empty_idx;
      upd.rank      = '0;
      upd.was_valid = 1'b0;
      upd.wr_page   = 1'b1;
    end else begin
      upd.idx       = pend_q.best_idx;
      upd.rank      = pend_q.best_rank;
      upd.was_valid = 1'b1;
      upd.wr_page   = 1'b1;
      evict         = 1'b1;
      evicted_page  = pend_q.best_page;
    end
  end

  // ---------------------------------------------------------------------------
  // Saturating counts and the result register
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]     fault_cnt_q, hit_cnt_q, fault_cnt_d, hit_cnt_d;
  logic                 res_hit_q, res_evict_q;
  logic [IDX_W-1:0]     res_idx_q;
  logic [PAGE_BITS-1:0] res_evpage_q;

  always_comb begin
    fault_cnt_d = fault_cnt_q;
    hit_cnt_d   = hit_cnt_q;
    if (pend_q.hit) begin
      if (hit_cnt_q != CNT_MAX) begin
        hit_cnt_d = hit_cnt_q + 1'b1;
      end
    end else if (fault_cnt_q != CNT_MAX) begin
      fault_cnt_d = fault_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_cnt_q <= '0;
      hit_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        fault_cnt_q <= fault_cnt_d;
        hit_cnt_q   <= hit_cnt_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_hit_q    <= pend_q.hit;
      res_idx_q    <= upd.idx;
      res_evict_q  <= evict;
      res_evpage_q <= evicted_page;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.hit           = res_hit_q;
  assign res_o.frame_index   = res_idx_q;
  assign res_o.evicted_valid = res_evict_q;
  assign res_o.evicted_page  = res_evpage_q;
  assign res_o.fault_total   = fault_cnt_q;
  assign res_o.hit_total     = hit_cnt_q;

`ifndef SYNTH
  // a token reaches the end of the row only for an item in flight, never twice
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_chain[FRAMES].vld |-> (busy_q && !pend_valid_q))
    else $error("search token at row end without a pending reference");

  // a decision retires the item and fills the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (!busy_q && res_valid_q))
    else $error("decision did not retire the reference");

  // when idle nothing is left in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (!pend_valid_q && !start_q))
    else $error("work in flight while idle");
`endif

endmodule
